// ----- hw/rtl/fixed_slot_pool_allocator_unit_defines.svh -----
// Assertion macros, included by fspa_back.sv.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FSPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fspa assertion failed");
`define FSPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fspa assertion failed");
`else
`define FSPA_ASSERT_NOW(lbl, ante, cons)
`define FSPA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/fspa_pkg.sv -----
package fspa_pkg;

  localparam int DEF_MAX_SLOTS  = 64;
  localparam int DEF_ADDR_WIDTH = 32;

  localparam int DATA_W     = 32;
  localparam int SB_W       = 7;
  localparam int CNT_REG_W  = 7;
  localparam int CFG_AW     = 4;
  localparam int CHUNK_BITS = 8;
  localparam int DIV_STEPS  = 4;
  localparam int CMDQ_DEPTH = 2;
  localparam int QP_W       = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int FILL_W     = $clog2(CMDQ_DEPTH + 1);

  localparam logic [1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [1:0] REG_SLOT_BYTES = 2'd1;
  localparam logic [1:0] REG_SLOT_COUNT = 2'd2;

  localparam logic [DATA_W-1:0]    RST_POOL_BASE  = '0;
  localparam logic [SB_W-1:0]      RST_SLOT_BYTES = 7'd4;
  localparam logic [CNT_REG_W-1:0] RST_SLOT_COUNT = '0;

  typedef enum logic [1:0] {
    ST_ALLOC  = 2'd0,
    ST_FULL   = 2'd1,
    ST_FREED  = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CK_ALLOC  = 2'd0,
    CK_FREE   = 2'd1,
    CK_REJECT = 2'd2
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SCAN,
    BS_MUL,
    BS_ADD,
    BS_DIV,
    BS_CHECK
  } bk_state_t;

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] slot_address;
    status_t           status;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [DATA_W-1:0] off;
  } cmd_t;

endpackage

// ----- hw/rtl/fspa_front.sv -----
module fspa_front import fspa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  in_item_t          in_item,
  input  logic [DATA_W-1:0] pool_base,
  input  logic              pool_empty,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_t              cmd_in;
  cmd_t              q_r [CMDQ_DEPTH];
  logic [QP_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              wr, rd;

  // classify: offset is only meaningful for a free that passes the range check
  always_comb begin
    cmd_in.off = in_item.free_address - pool_base;
    priority if (!in_item.mode) begin
      cmd_in.kind = CK_ALLOC;
    end else if (in_item.free_address != '0 && !pool_empty &&
                 in_item.free_address >= pool_base) begin
      cmd_in.kind = CK_FREE;
    end else begin
      cmd_in.kind = CK_REJECT;
    end
  end

  assign in_full   = (fill_r == FILL_W'(CMDQ_DEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign wr        = in_push && !in_full;
  assign rd        = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(CMDQ_DEPTH - 1)) ? '0 : QP_W'(wr_ptr_r + 1'b1);
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(CMDQ_DEPTH - 1)) ? '0 : QP_W'(rd_ptr_r + 1'b1);
    end
    unique case ({wr, rd})
      2'b10:   fill_nxt = FILL_W'(fill_r + 1'b1);
      2'b01:   fill_nxt = FILL_W'(fill_r - 1'b1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- hw/rtl/fspa_back.sv -----
`include "fixed_slot_pool_allocator_unit_defines.svh"
module fspa_back import fspa_pkg::*; #(
  parameter  int MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter  int ADDR_WIDTH = DEF_ADDR_WIDTH,
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  input  logic [DATA_W-1:0] pool_base,
  input  logic [SB_W-1:0]   sb_eff,
  input  logic [CNT_W-1:0]  cnt_eff,
  output logic              out_empty,
  input  logic              out_pop,
  output out_item_t         out_item
);

  localparam int NCHUNK    = (MAX_SLOTS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int MAP_W     = NCHUNK * CHUNK_BITS;
  localparam int MAP_IDX_W = $clog2(MAP_W);
  localparam int CH_W      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int SUB_W     = $clog2(CHUNK_BITS);
  localparam int RES_W     = (ADDR_WIDTH < DATA_W) ? ADDR_WIDTH : DATA_W;
  localparam int PROD_W    = MAP_IDX_W + SB_W;
  localparam int DIV_CYC   = DATA_W / DIV_STEPS;
  localparam int DC_W      = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  bk_state_t            state_r, state_nxt;
  logic [MAP_W-1:0]     used_r, used_nxt;
  logic [CH_W-1:0]      chunk_r, chunk_nxt;
  logic [MAP_IDX_W-1:0] slot_idx_r, slot_idx_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [SB_W-1:0]      rem_r, rem_nxt;
  logic [DATA_W-1:0]    dq_r, dq_nxt;
  logic [DC_W-1:0]      div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic [CHUNK_BITS-1:0] chunk_bits;
  logic [MAP_IDX_W-1:0]  chunk_base;
  logic [MAP_IDX_W-1:0]  pick;
  logic                  found;
  logic                  last_chunk;
  logic [SB_W-1:0]       rem_step;
  logic [DATA_W-1:0]     dq_step;
  logic [DATA_W-1:0]     sum;
  logic                  out_free;
  logic                  res_wr;
  out_item_t             res;

  // search one chunk of the used map per cycle, lowest free slot wins
  assign chunk_bits = used_r[chunk_r * CHUNK_BITS +: CHUNK_BITS];
  assign chunk_base = MAP_IDX_W'({chunk_r, SUB_W'(0)});
  assign last_chunk = (chunk_r == CH_W'(NCHUNK - 1)) ||
                      (32'(chunk_base) + 32'(CHUNK_BITS) >= 32'(cnt_eff));

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int j = CHUNK_BITS - 1; j >= 0; j--) begin
      if (!chunk_bits[j] && (32'(chunk_base + MAP_IDX_W'(j)) < 32'(cnt_eff))) begin
        found = 1'b1;
        pick  = chunk_base + MAP_IDX_W'(j);
      end
    end
  end

  // restoring division, DIV_STEPS quotient bits per cycle
  always_comb begin
    logic [SB_W:0] t;
    logic          qbit;
    rem_step = rem_r;
    dq_step  = dq_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t = {rem_step, dq_step[DATA_W-1]};
      if (t >= {1'b0, sb_eff}) begin
        rem_step = SB_W'(t - {1'b0, sb_eff});
        qbit     = 1'b1;
      end else begin
        rem_step = t[SB_W-1:0];
        qbit     = 1'b0;
      end
      dq_step = {dq_step[DATA_W-2:0], qbit};
    end
  end

  assign sum      = pool_base + DATA_W'(prod_r);
  assign out_free = !out_valid_r || out_pop;

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    chunk_nxt    = chunk_r;
    slot_idx_nxt = slot_idx_r;
    prod_nxt     = prod_r;
    rem_nxt      = rem_r;
    dq_nxt       = dq_r;
    div_cnt_nxt  = div_cnt_r;
    cmd_ready    = 1'b0;
    res_wr       = 1'b0;
    res          = '{slot_address: '0, status: ST_REJECT};
    unique case (state_r)
      BS_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CK_ALLOC: begin
              cmd_ready = 1'b1;
              chunk_nxt = '0;
              state_nxt = BS_SCAN;
            end
            CK_FREE: begin
              cmd_ready   = 1'b1;
              rem_nxt     = '0;
              dq_nxt      = cmd.off;
              div_cnt_nxt = '0;
              state_nxt   = BS_DIV;
            end
            CK_REJECT: begin
              if (out_free) begin
                cmd_ready  = 1'b1;
                res_wr     = 1'b1;
                res.status = ST_REJECT;
              end
            end
            default: begin
              cmd_ready = 1'b1;
            end
          endcase
        end
      end
      BS_SCAN: begin
        if (found) begin
          used_nxt[pick] = 1'b1;
          slot_idx_nxt   = pick;
          state_nxt      = BS_MUL;
        end else if (last_chunk) begin
          if (out_free) begin
            res_wr     = 1'b1;
            res.status = ST_FULL;
            state_nxt  = BS_IDLE;
          end
        end else begin
          chunk_nxt = CH_W'(chunk_r + 1'b1);
        end
      end
      BS_MUL: begin
        prod_nxt  = PROD_W'(slot_idx_r) * PROD_W'(sb_eff);
        state_nxt = BS_ADD;
      end
      BS_ADD: begin
        if (out_free) begin
          res_wr           = 1'b1;
          res.slot_address = DATA_W'(sum[RES_W-1:0]);
          res.status       = ST_ALLOC;
          state_nxt        = BS_IDLE;
        end
      end
      BS_DIV: begin
        rem_nxt     = rem_step;
        dq_nxt      = dq_step;
        div_cnt_nxt = DC_W'(div_cnt_r + 1'b1);
        if (div_cnt_r == DC_W'(DIV_CYC - 1)) begin
          state_nxt = BS_CHECK;
        end
      end
      BS_CHECK: begin
        if (out_free) begin
          res_wr    = 1'b1;
          state_nxt = BS_IDLE;
          if (rem_r == '0 && dq_r < DATA_W'(cnt_eff)) begin
            used_nxt[dq_r[MAP_IDX_W-1:0]] = 1'b0;
            res.status = ST_FREED;
          end else begin
            res.status = ST_REJECT;
          end
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (res_wr) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end else if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chunk_r    <= chunk_nxt;
    slot_idx_r <= slot_idx_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  `FSPA_ASSERT_NEXT(a_alloc_marks_slot, state_r == BS_SCAN && found, used_r[slot_idx_r])
  `FSPA_ASSERT_NOW(a_nonalloc_zero_addr, out_valid_r && out_item_r.status != ST_ALLOC, out_item_r.slot_address == '0)
  `FSPA_ASSERT_NOW(a_take_only_idle, cmd_ready, state_r == BS_IDLE && cmd_valid)
  `FSPA_ASSERT_NEXT(a_div_ends_in_check, state_r == BS_DIV && div_cnt_r == DC_W'(DIV_CYC - 1), state_r == BS_CHECK)

endmodule

// ----- hw/rtl/fixed_slot_pool_allocator_unit.sv -----
// Fixed-size slot pool allocator with a used-bit map.
// Input queue side: drive in_item and raise in_push; the item is taken on a
// clock edge where in_full is low. mode 0 allocates the lowest free slot,
// mode 1 frees the slot at free_address.
// Result queue side: while out_empty is low, out_item holds the oldest result;
// raise out_pop to take it. One result per item, in order.
// Configuration: APB-style writes to pool_base (0x0), slot_bytes (0x4) and
// slot_count (0x8); write only while no item is in flight.
// A rejected free goes from the command queue straight to the result; a free
// divides the offset by the slot size, 4 bits a cycle, then checks the
// remainder and the slot index; an allocate scans the used map in 8-slot
// chunks, then multiplies the index by the slot size and adds pool_base. One
// item is worked at a time; a two-entry command queue accepts up to two more.
// Reset clears the used map (every slot free), both queues and the registers
// to pool_base 0, slot_bytes 4, slot_count 0.
// When out_pop stays low, the finished result is held, the engine waits with
// its next result, and in_full rises once the command queue is full.
module fixed_slot_pool_allocator_unit import fspa_pkg::*; #(
  parameter  int MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter  int ADDR_WIDTH = DEF_ADDR_WIDTH,
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  in_item_t          in_item,
  output logic              out_empty,
  input  logic              out_pop,
  output out_item_t         out_item,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [DATA_W-1:0]    pool_base_r;
  logic [SB_W-1:0]      slot_bytes_r;
  logic [CNT_REG_W-1:0] slot_count_r;
  logic [1:0]           reg_idx;
  logic                 cfg_wr;
  logic [SB_W-1:0]      sb_eff;
  logic [CNT_W-1:0]     cnt_eff;
  logic                 pool_empty;
  logic                 cmd_valid;
  logic                 cmd_ready;
  cmd_t                 cmd;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= RST_POOL_BASE;
      slot_bytes_r <= RST_SLOT_BYTES;
      slot_count_r <= RST_SLOT_COUNT;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_POOL_BASE:  pool_base_r  <= cfg_pwdata;
        REG_SLOT_BYTES: slot_bytes_r <= cfg_pwdata[SB_W-1:0];
        REG_SLOT_COUNT: slot_count_r <= cfg_pwdata[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POOL_BASE:  cfg_prdata = pool_base_r;
      REG_SLOT_BYTES: cfg_prdata = DATA_W'(slot_bytes_r);
      REG_SLOT_COUNT: cfg_prdata = DATA_W'(slot_count_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign sb_eff     = (slot_bytes_r == '0) ? SB_W'(1) : slot_bytes_r;
  assign cnt_eff    = (32'(slot_count_r) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                           : CNT_W'(slot_count_r);
  assign pool_empty = (cnt_eff == '0);

  fspa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_item    (in_item),
    .pool_base  (pool_base_r),
    .pool_empty (pool_empty),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  fspa_back #(
    .MAX_SLOTS  (MAX_SLOTS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .pool_base  (pool_base_r),
    .sb_eff     (sb_eff),
    .cnt_eff    (cnt_eff),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

endmodule
